// File: hw/rtl/prq_pkg.sv
`default_nettype none

package prq_pkg;

  localparam int unsigned DefaultDepth = 32;
  localparam logic [7:0]  PromoteReset = 8'd20;

  localparam int unsigned PrioW    = 8;
  localparam int unsigned HashW    = 256;
  localparam int unsigned ClientW  = 16;
  localparam int unsigned OutCntW  = 6;
  localparam int unsigned InDataW  = 280;
  localparam int unsigned OutDataW = 296;
  localparam int unsigned UserW    = 2;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_PROMOTE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NO_MATCH = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [PrioW-1:0]   prio;
    logic [HashW-1:0]   hash;
    logic [ClientW-1:0] client;
  } entry_t;

  typedef struct packed {
    logic vld;
    op_e  op;
    logic found;
  } tok_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/prq_cell.sv
`default_nettype none

module prq_cell #(
  parameter int unsigned DEPTH   = prq_pkg::DefaultDepth,
  parameter int unsigned CellIdx = 0,
  parameter int unsigned IDX_W   = $clog2(DEPTH),
  parameter int unsigned CNT_W   = $clog2(DEPTH + 1)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [CNT_W-1:0]          fill_i,
  input  wire logic [prq_pkg::PrioW-1:0] promote_prio_i,
  input  wire prq_pkg::tok_ctl_t         tok_ctl_i,
  input  wire prq_pkg::entry_t           tok_ent_i,
  input  wire logic [IDX_W-1:0]          tok_idx_i,
  input  wire logic [CNT_W-1:0]          tok_cnt_i,
  output prq_pkg::tok_ctl_t              tok_ctl_o,
  output prq_pkg::entry_t                tok_ent_o,
  output logic [IDX_W-1:0]               tok_idx_o,
  output logic [CNT_W-1:0]               tok_cnt_o,
  input  wire logic                      shift_i,
  input  wire logic [IDX_W-1:0]          shift_idx_i,
  input  wire prq_pkg::entry_t           nbr_ent_i,
  output prq_pkg::entry_t                ent_o
);
  import prq_pkg::*;

  entry_t           ent_q, ent_d;
  tok_ctl_t         tok_ctl_q, tok_ctl_d;
  entry_t           tok_ent_q, tok_ent_d;
  logic [IDX_W-1:0] tok_idx_q, tok_idx_d;
  logic [CNT_W-1:0] tok_cnt_q, tok_cnt_d;
  logic             occupied;
  logic             hash_hit;

  assign occupied = CNT_W'(CellIdx) < fill_i;
  assign hash_hit = tok_ent_i.hash == ent_q.hash;

  always_comb begin
    ent_d     = ent_q;
    tok_ctl_d = tok_ctl_i;
    tok_ent_d = tok_ent_i;
    tok_idx_d = tok_idx_i;
    tok_cnt_d = tok_cnt_i;
    if (tok_ctl_i.vld) begin
      case (tok_ctl_i.op)
        OP_ENQUEUE: begin
          if (CNT_W'(CellIdx) == fill_i) begin
            ent_d           = tok_ent_i;
            tok_ctl_d.found = 1'b1;
          end
        end
        OP_DEQUEUE: begin
          if (occupied && (!tok_ctl_i.found || ent_q.prio > tok_ent_i.prio)) begin
            tok_ent_d       = ent_q;
            tok_idx_d       = IDX_W'(CellIdx);
            tok_ctl_d.found = 1'b1;
          end
        end
        OP_PROMOTE: begin
          if (occupied && hash_hit) begin
            ent_d.prio = promote_prio_i;
            tok_cnt_d  = CNT_W'(tok_cnt_i + 1'b1);
          end
        end
        default: begin
        end
      endcase
    end
    if (shift_i && IDX_W'(CellIdx) >= shift_idx_i) begin
      ent_d = nbr_ent_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_ctl_q <= '0;
    end else begin
      tok_ctl_q <= tok_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q     <= ent_d;
    tok_ent_q <= tok_ent_d;
    tok_idx_q <= tok_idx_d;
    tok_cnt_q <= tok_cnt_d;
  end

  assign tok_ctl_o = tok_ctl_q;
  assign tok_ent_o = tok_ent_q;
  assign tok_idx_o = tok_idx_q;
  assign tok_cnt_o = tok_cnt_q;
  assign ent_o     = ent_q;

endmodule

`default_nettype wire

// File: hw/rtl/priority_request_queue_unit.sv
// Each request beat sends one token down a row of DEPTH cells, one cell per cycle.
// The token leaves the last cell into the finish registers; from there the result is
// loaded into the output register once that register is free, and is offered from it.
// A new request is taken only once the previous result is loaded, one request at a time.
// Reset empties the queue and sets the promote priority to 20; entry contents are
// left as they are and are never read before they are written.
`default_nettype none

module priority_request_queue_unit #(
  parameter int unsigned DEPTH = prq_pkg::DefaultDepth
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [prq_pkg::PrioW-1:0]    cfg_data_i,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // req_prio, hash_w0, hash_w1, hash_w2, hash_w3, req_client
  input  wire logic [prq_pkg::InDataW-1:0]  s_axis_tdata,
  // op
  input  wire logic [prq_pkg::UserW-1:0]    s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // out_prio, out_hash_w0, out_hash_w1, out_hash_w2, out_hash_w3, out_client,
  // match_count, entry_count, zero fill
  output logic [prq_pkg::OutDataW-1:0]      m_axis_tdata,
  // status
  output logic [prq_pkg::UserW-1:0]         m_axis_tuser
);
  import prq_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned PadW  = OutDataW - (PrioW + HashW + ClientW + 2 * OutCntW);

  tok_ctl_t         tok_ctl [DEPTH+1];
  entry_t           tok_ent [DEPTH+1];
  logic [IDX_W-1:0] tok_idx [DEPTH+1];
  logic [CNT_W-1:0] tok_cnt [DEPTH+1];
  entry_t           cell_ent [DEPTH];

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic [PrioW-1:0]    promote_q;
  tok_ctl_t            fin_ctl_q;
  entry_t              fin_ent_q;
  logic [IDX_W-1:0]    fin_idx_q;
  logic [CNT_W-1:0]    fin_cnt_q;
  logic                finish;
  logic                shift;
  logic                in_beat;
  logic                m_valid_q, m_valid_d;
  logic [OutDataW-1:0] m_data_q, m_data_d;
  status_e             m_status_q, m_status_d;
  entry_t              res_ent;
  logic [CNT_W-1:0]    res_match;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = state_q == S_IDLE;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  assign tok_ctl[0] = '{vld: in_beat, op: op_e'(s_axis_tuser), found: 1'b0};
  assign tok_ent[0] = '{prio:   s_axis_tdata[PrioW-1:0],
                        hash:   s_axis_tdata[PrioW+HashW-1:PrioW],
                        client: s_axis_tdata[InDataW-1:PrioW+HashW]};
  assign tok_idx[0] = '0;
  assign tok_cnt[0] = '0;

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    entry_t nbr_ent;
    if (gi == DEPTH - 1) begin : g_tail
      assign nbr_ent = cell_ent[gi];
    end else begin : g_body
      assign nbr_ent = cell_ent[gi+1];
    end
    prq_cell #(
      .DEPTH   (DEPTH),
      .CellIdx (gi),
      .IDX_W   (IDX_W),
      .CNT_W   (CNT_W)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .fill_i         (fill_q),
      .promote_prio_i (promote_q),
      .tok_ctl_i      (tok_ctl[gi]),
      .tok_ent_i      (tok_ent[gi]),
      .tok_idx_i      (tok_idx[gi]),
      .tok_cnt_i      (tok_cnt[gi]),
      .tok_ctl_o      (tok_ctl[gi+1]),
      .tok_ent_o      (tok_ent[gi+1]),
      .tok_idx_o      (tok_idx[gi+1]),
      .tok_cnt_o      (tok_cnt[gi+1]),
      .shift_i        (shift),
      .shift_idx_i    (fin_idx_q),
      .nbr_ent_i      (nbr_ent),
      .ent_o          (cell_ent[gi])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fill_q    <= '0;
      promote_q <= PromoteReset;
      m_valid_q <= 1'b0;
      fin_ctl_q <= '0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        promote_q <= cfg_data_i;
      end
      if (tok_ctl[DEPTH].vld) begin
        fin_ctl_q <= tok_ctl[DEPTH];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_ctl[DEPTH].vld) begin
      fin_ent_q <= tok_ent[DEPTH];
      fin_idx_q <= tok_idx[DEPTH];
      fin_cnt_q <= tok_cnt[DEPTH];
    end
    if (finish) begin
      m_data_q   <= m_data_d;
      m_status_q <= m_status_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    finish     = 1'b0;
    shift      = 1'b0;
    res_ent    = '0;
    res_match  = '0;
    m_status_d = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tok_ctl[DEPTH].vld) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!m_valid_q || m_axis_tready) begin
          finish  = 1'b1;
          state_d = S_IDLE;
          case (fin_ctl_q.op)
            OP_ENQUEUE: begin
              if (fin_ctl_q.found) begin
                fill_d = CNT_W'(fill_q + 1'b1);
              end else begin
                m_status_d = ST_FULL;
              end
            end
            OP_DEQUEUE: begin
              if (fin_ctl_q.found) begin
                res_ent = fin_ent_q;
                shift   = 1'b1;
                fill_d  = CNT_W'(fill_q - 1'b1);
              end else begin
                m_status_d = ST_EMPTY;
              end
            end
            OP_PROMOTE: begin
              res_match  = fin_cnt_q;
              m_status_d = (fin_cnt_q == '0) ? ST_NO_MATCH : ST_OK;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign m_data_d  = {{PadW{1'b0}}, OutCntW'(fill_d), OutCntW'(res_match),
                      res_ent.client, res_ent.hash, res_ent.prio};
  assign m_valid_d = finish ? 1'b1 : (m_valid_q && !m_axis_tready);

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_status_q;

  a_tail_only_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_ctl[DEPTH].vld |-> state_q == S_SCAN)
    else $error("token left the cell row outside a scan");

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(DEPTH))
    else $error("fill level beyond queue depth");

  a_beat_starts_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> state_q == S_SCAN && !s_axis_tready)
    else $error("request beat did not start a scan");

  a_dequeue_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift |=> fill_q + 1'b1 == $past(fill_q))
    else $error("dequeue did not lower the fill level by one");

  a_finish_loads_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> m_axis_tvalid)
    else $error("finished request produced no result beat");

endmodule

`default_nettype wire

// File: bench/priority_request_queue_unit_tb.sv
`default_nettype none

module priority_request_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import prq_pkg::*;

  localparam int unsigned Depth         = DefaultDepth;
  localparam logic [1:0]  OpUnused      = 2'd3;
  localparam int unsigned PhaseCount    = 6;
  localparam int unsigned ItemsPerPhase = 150;
  localparam int unsigned PoolSize      = 8;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BALANCED
  } mix_e;

  typedef struct {
    status_e            status;
    logic [PrioW-1:0]   prio;
    logic [HashW-1:0]   hash;
    logic [ClientW-1:0] client;
    logic [OutCntW-1:0] hits;
    logic [OutCntW-1:0] fill;
  } queue_result_t;

  class prq_scoreboard;
    logic [PrioW-1:0]   slot_prio[Depth];
    logic [HashW-1:0]   slot_hash[Depth];
    logic [ClientW-1:0] slot_client[Depth];
    int unsigned        fill;
    logic [PrioW-1:0]   promote_prio;
    queue_result_t      pending_results[$];
    int unsigned        errors;
    int unsigned        n_enq, n_full, n_deq, n_empty, n_promote, n_promoted, n_unused;

    function new();
      fill         = 0;
      promote_prio = PromoteReset;
      errors       = 0;
      n_enq        = 0;
      n_full       = 0;
      n_deq        = 0;
      n_empty      = 0;
      n_promote    = 0;
      n_promoted   = 0;
      n_unused     = 0;
    endfunction

    function void set_promote(logic [PrioW-1:0] value);
      promote_prio = value;
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    function void note_request(logic [1:0] op, logic [PrioW-1:0] prio,
                               logic [HashW-1:0] hash, logic [ClientW-1:0] client);
      queue_result_t r;
      int unsigned   best;
      int unsigned   hits;
      r.status = ST_OK;
      r.prio   = '0;
      r.hash   = '0;
      r.client = '0;
      r.hits   = '0;
      case (op)
        OP_ENQUEUE: begin
          n_enq++;
          if (fill >= Depth) begin
            r.status = ST_FULL;
            n_full++;
          end else begin
            slot_prio[fill]   = prio;
            slot_hash[fill]   = hash;
            slot_client[fill] = client;
            fill++;
          end
        end
        OP_DEQUEUE: begin
          n_deq++;
          if (fill == 0) begin
            r.status = ST_EMPTY;
            n_empty++;
          end else begin
            best = 0;
            for (int unsigned i = 1; i < fill; i++) begin
              if (slot_prio[i] > slot_prio[best]) best = i;
            end
            r.prio   = slot_prio[best];
            r.hash   = slot_hash[best];
            r.client = slot_client[best];
            for (int unsigned i = best; i + 1 < fill; i++) begin
              slot_prio[i]   = slot_prio[i+1];
              slot_hash[i]   = slot_hash[i+1];
              slot_client[i] = slot_client[i+1];
            end
            fill--;
          end
        end
        OP_PROMOTE: begin
          n_promote++;
          hits = 0;
          for (int unsigned i = 0; i < fill; i++) begin
            if (slot_hash[i] == hash) begin
              slot_prio[i] = promote_prio;
              hits++;
            end
          end
          n_promoted += hits;
          r.status = (hits == 0) ? ST_NO_MATCH : ST_OK;
          r.hits   = OutCntW'(hits);
        end
        default: begin
          n_unused++;
        end
      endcase
      r.fill = OutCntW'(fill);
      pending_results.push_back(r);
    endfunction

    function void check_field(string name, logic [HashW-1:0] want, logic [HashW-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OutDataW-1:0] data, logic [UserW-1:0] user);
      queue_result_t w;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with no request waiting, expected none, actual status %0d",
                 $time, user);
        errors++;
        return;
      end
      w = pending_results.pop_front();
      check_field("status", HashW'(w.status), HashW'(user));
      check_field("out_prio", HashW'(w.prio), HashW'(data[7:0]));
      check_field("out_hash", w.hash, data[263:8]);
      check_field("out_client", HashW'(w.client), HashW'(data[279:264]));
      check_field("match_count", HashW'(w.hits), HashW'(data[285:280]));
      check_field("entry_count", HashW'(w.fill), HashW'(data[291:286]));
      check_field("padding", '0, HashW'(data[295:292]));
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [PrioW-1:0]    cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [UserW-1:0]    s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [UserW-1:0]    m_axis_tuser;

  prq_scoreboard    sb;
  logic [HashW-1:0] hash_pool[PoolSize];
  int unsigned      burst_left;
  logic [15:0]      stall_cycle;
  logic [1:0]       stall_mode;

  priority_request_queue_unit #(
    .DEPTH(Depth)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The receiver picks a mode at random whenever stall_cycle[5:0] is zero: always ready,
  // light random stalls, a fixed on/off pattern or long random stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_cycle   <= '0;
      stall_mode    <= '0;
    end else begin
      stall_cycle <= stall_cycle + 16'd1;
      if (stall_cycle[5:0] == 6'd0) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
        2'd0: begin
          m_axis_tready <= 1'b1;
        end
        2'd1: begin
          m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
        2'd2: begin
          m_axis_tready <= stall_cycle[3];
        end
        default: begin
          m_axis_tready <= ($urandom_range(0, 7) == 0);
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  function automatic logic [HashW-1:0] random_hash();
    logic [HashW-1:0] h;
    for (int i = 0; i < HashW / 32; i++) h[i*32 +: 32] = $urandom;
    return h;
  endfunction

  function automatic logic [HashW-1:0] pick_hash(int unsigned fresh_pct);
    if ($urandom_range(0, 99) < fresh_pct) return random_hash();
    return hash_pool[$urandom_range(0, PoolSize - 1)];
  endfunction

  function automatic logic [PrioW-1:0] pick_prio();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3, 4: return PrioW'($urandom_range(0, 15));
      default: return PrioW'($urandom);
    endcase
  endfunction

  task automatic send_request(logic [1:0] op, logic [PrioW-1:0] prio,
                              logic [HashW-1:0] hash, logic [ClientW-1:0] client);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {client, hash, prio};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sb.note_request(op, prio, hash, client);
    burst_left = (burst_left > 0) ? burst_left - 1 : 0;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
    end
  endtask

  task automatic drain_queue();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic write_promote(logic [PrioW-1:0] value);
    drain_queue();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.set_promote(value);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_request(mix_e mix);
    int unsigned roll;
    int unsigned enq_pct;
    int unsigned deq_pct;
    logic [1:0]  op;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        enq_pct = 65;
        deq_pct = 20;
      end
      MIX_DRAIN: begin
        enq_pct = 25;
        deq_pct = 60;
      end
      default: begin
        enq_pct = 45;
        deq_pct = 40;
      end
    endcase
    if (roll < enq_pct) op = OP_ENQUEUE;
    else if (roll < enq_pct + deq_pct) op = OP_DEQUEUE;
    else if (roll < 98) op = OP_PROMOTE;
    else op = OpUnused;
    send_request(op, pick_prio(), pick_hash(op == OP_PROMOTE ? 25 : 30),
                 ClientW'($urandom_range(0, 65535)));
  endtask

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [PrioW-1:0] promote_values[PhaseCount];
    sb         = new();
    burst_left = 8;
    hash_pool[0] = '0;
    hash_pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) hash_pool[i] = random_hash();
    promote_values = '{8'd255, 8'd0, 8'($urandom), 8'd20, 8'($urandom), 8'd128};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, run with the promote priority still at its reset value.
    send_request(OpUnused, '1, random_hash(), 16'hffff);
    send_request(OP_DEQUEUE, '0, '0, '0);
    send_request(OP_PROMOTE, '0, hash_pool[1], '0);
    send_request(OP_ENQUEUE, 8'd0, '0, 16'h0000);
    send_request(OP_ENQUEUE, 8'd255, '1, 16'hffff);
    send_request(OP_ENQUEUE, 8'd255, hash_pool[2], 16'h1234);
    send_request(OP_ENQUEUE, 8'd7, '1, 16'h0005);
    send_request(OP_PROMOTE, '0, '1, '0);
    send_request(OP_PROMOTE, '0, hash_pool[3], '0);
    send_request(OpUnused, 8'h5a, random_hash(), 16'h8001);
    send_request(OP_DEQUEUE, '0, '0, '0);
    send_request(OP_DEQUEUE, '0, '0, '0);
    send_request(OP_DEQUEUE, '0, '0, '0);
    send_request(OP_DEQUEUE, '0, '0, '0);
    send_request(OP_DEQUEUE, '0, '0, '0);
    send_request(OP_ENQUEUE, 8'd9, hash_pool[4], 16'h7fff);
    send_request(OP_PROMOTE, '0, hash_pool[4], '0);

    for (int p = 0; p < PhaseCount; p++) begin
      write_promote(promote_values[p]);
      for (int unsigned n = 0; n < ItemsPerPhase; n++) random_request(mix_e'(p % 3));
    end

    drain_queue();
    repeat (Depth + 4) @(posedge clk_i);
    $display("Covered %0d enqueues (%0d dropped on full), %0d dequeues (%0d on empty),",
             sb.n_enq, sb.n_full, sb.n_deq, sb.n_empty);
    $display("%0d promotes raising %0d entries, %0d unused opcodes, %0d promote settings.",
             sb.n_promote, sb.n_promoted, sb.n_unused, PhaseCount);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
